### rtl/assert_macros.svh
// Assertion macros used by the checker file tlr_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under clock and active-low reset.
`define TLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under clock and active-low reset.
`define TLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tlr_pkg.sv
// Types, codes and constants of the thick line rasteriser.
// No dependencies; imported by the front end, back end and top level.
package tlr_pkg;

	localparam int TLR_MAX_ROWS       = 256;
	localparam int TLR_MAX_COLS       = 256;
	localparam int TLR_MAX_LINE_WIDTH = 31;

	localparam int DIM_W  = 13;	// clamped image bound, up to 8191
	localparam int HALF_W = 7;	// brush half-width, up to 127
	localparam int PIX_W  = 24;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] REG_COLOR  = 2'd0;
	localparam logic [1:0] REG_LWIDTH = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_WIDTH  = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [11:0] start_col;
		logic signed [11:0] start_row;
		logic signed [11:0] end_col;
		logic signed [11:0] end_row;
		logic [23:0]        pixel_in;
	} tlr_item_t;

	typedef struct packed {
		logic [23:0] pixel_out;
		logic        status;
	} tlr_result_t;

	// Classified command. Accesses use a1 as row, b1 as column.
	typedef struct packed {
		logic [1:0]         op;
		logic               oob;
		logic               col_major;
		logic signed [11:0] a1;
		logic signed [11:0] b1;
		logic signed [11:0] lo;
		logic signed [11:0] hi;
		logic signed [12:0] dmaj;
		logic signed [12:0] dmin;
		logic [23:0]        pixel;
	} tlr_op_t;

endpackage

### rtl/tlr_front.sv
// Front end: takes items, classifies them and queues them for the back end.
// Depends on tlr_pkg.
module tlr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  tlr_pkg::tlr_item_t         item,
	input  logic [tlr_pkg::DIM_W-1:0]  rows_lim,
	input  logic [tlr_pkg::DIM_W-1:0]  cols_lim,
	output logic                       op_valid,
	input  logic                       op_ready,
	output tlr_pkg::tlr_op_t           op
);
	import tlr_pkg::*;

	tlr_op_t            cls;
	tlr_op_t            fifo_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         count_q;
	logic signed [12:0] dr, dc;
	logic [12:0]        adr, adc;
	logic signed [13:0] sr_x, sc_x, h_x, w_x;
	logic               do_push, do_pop;

	always_comb begin
		dr   = 13'(item.end_row) - 13'(item.start_row);
		dc   = 13'(item.end_col) - 13'(item.start_col);
		adr  = dr < 0 ? 13'(-dr) : 13'(dr);
		adc  = dc < 0 ? 13'(-dc) : 13'(dc);
		sr_x = 14'(item.start_row);
		sc_x = 14'(item.start_col);
		h_x  = $signed({1'b0, rows_lim});
		w_x  = $signed({1'b0, cols_lim});

		cls           = '0;
		cls.op        = item.cmd;
		cls.pixel     = item.pixel_in;
		cls.col_major = adr < adc;
		unique case (item.cmd)
			OP_DRAW: begin
				if (adr < adc) begin
					cls.a1   = item.start_col;
					cls.b1   = item.start_row;
					cls.dmaj = dc;
					cls.dmin = dr;
					cls.lo   = item.start_col < item.end_col ? item.start_col : item.end_col;
					cls.hi   = item.start_col < item.end_col ? item.end_col : item.start_col;
				end else begin
					cls.a1   = item.start_row;
					cls.b1   = item.start_col;
					cls.dmaj = dr;
					cls.dmin = dc;
					cls.lo   = item.start_row < item.end_row ? item.start_row : item.end_row;
					cls.hi   = item.start_row < item.end_row ? item.end_row : item.start_row;
				end
			end
			OP_WRITE, OP_READ: begin
				cls.a1  = item.start_row;
				cls.b1  = item.start_col;
				cls.oob = sr_x < 0 || sc_x < 0 || sr_x >= h_x || sc_x >= w_x;
			end
			default: cls.op = OP_NONE;
		endcase
	end

	assign full     = count_q == 2'd2;
	assign op_valid = count_q != 2'd0;
	assign op       = fifo_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = op_valid && op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) fifo_q[wr_ptr_q] <= cls;
	end

endmodule

### rtl/tlr_back.sv
// Back end: frame store, line stepper with serial divider, brush painter,
// result register. Depends on tlr_pkg.
module tlr_back #(
	parameter int MAX_ROWS = tlr_pkg::TLR_MAX_ROWS,
	parameter int MAX_COLS = tlr_pkg::TLR_MAX_COLS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tlr_pkg::tlr_op_t           op,
	input  logic                       op_valid,
	output logic                       op_ready,
	input  logic [23:0]                color,
	input  logic [tlr_pkg::HALF_W-1:0] half,
	input  logic [tlr_pkg::DIM_W-1:0]  rows_lim,
	input  logic [tlr_pkg::DIM_W-1:0]  cols_lim,
	input  logic                       pop,
	output logic                       res_valid,
	output tlr_pkg::tlr_result_t       result
);
	import tlr_pkg::*;

	localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_RESP  = 4'd2;
	localparam logic [3:0] S_BASE  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_DIVI  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_BSET  = 4'd7;
	localparam logic [3:0] S_PAINT = 4'd8;
	localparam logic [3:0] S_NEXT  = 4'd9;

	logic [3:0]         state_q;
	tlr_op_t            cur_q;
	logic signed [11:0] i_q;
	logic signed [24:0] bprod_q;
	logic signed [25:0] prod_q;
	logic [26:0]        n_q;
	logic [12:0]        rem_q;
	logic [4:0]         cnt_q;
	logic               neg_q;
	logic signed [13:0] r_q, c_q, c0_q, rend_q, cend_q;
	logic [23:0]        pend_pix_q;
	logic               pend_st_q;
	logic               res_valid_q;
	tlr_result_t        res_q;

	logic [PIX_W-1:0]   mem [MAX_ROWS*MAX_COLS];
	logic [PIX_W-1:0]   rd_data_q;

	logic               mem_we, mem_re;
	logic signed [13:0] a_row, a_col;
	logic [AW-1:0]      addr;
	logic [23:0]        mem_wdata;

	logic signed [26:0] num;
	logic [26:0]        nabs;
	logic [12:0]        dabs;
	logic [13:0]        trial;
	logic               qbit;
	logic signed [12:0] m_val;
	logic signed [13:0] row_c, col_c, r_lo, r_hi, c_lo, c_hi, r0, rend, c0, cend;
	logic signed [13:0] h_x, w_x, half_x;
	logic               out_free;

	assign op_ready  = state_q == S_IDLE;
	assign res_valid = res_valid_q;
	assign result    = res_q;
	assign out_free  = !res_valid_q || pop;

	// Frame store port
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		a_row     = 14'(op.a1);
		a_col     = 14'(op.b1);
		mem_wdata = op.pixel;
		if (state_q == S_PAINT) begin
			mem_we    = 1'b1;
			a_row     = r_q;
			a_col     = c_q;
			mem_wdata = color;
		end else if (state_q == S_IDLE && op_valid && !op.oob) begin
			mem_we = op.op == OP_WRITE;
			mem_re = op.op == OP_READ;
		end
		addr = AW'(a_row[RW-1:0]) * AW'(MAX_COLS) + AW'(a_col[CW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[addr];
	end

	// Datapath helpers
	always_comb begin
		num    = 27'(prod_q) + 27'(bprod_q);
		nabs   = num < 0 ? 27'(-num) : 27'(num);
		dabs   = cur_q.dmaj < 0 ? 13'(-cur_q.dmaj) : 13'(cur_q.dmaj);
		trial  = {rem_q, n_q[26]};
		qbit   = trial >= {1'b0, dabs};
		m_val  = neg_q ? -$signed(n_q[12:0]) : $signed(n_q[12:0]);
		h_x    = $signed({1'b0, rows_lim});
		w_x    = $signed({1'b0, cols_lim});
		half_x = $signed(14'(half));
		row_c  = cur_q.col_major ? 14'(m_val) : 14'(i_q);
		col_c  = cur_q.col_major ? 14'(i_q) : 14'(m_val);
		r_lo   = row_c - half_x;
		r_hi   = row_c + half_x + 14'sd1;
		c_lo   = col_c - half_x;
		c_hi   = col_c + half_x + 14'sd1;
		r0     = r_lo < 0 ? 14'sd0 : r_lo;
		rend   = r_hi > h_x ? h_x : r_hi;
		c0     = c_lo < 0 ? 14'sd0 : c_lo;
		cend   = c_hi > w_x ? w_x : c_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// a new result in S_RESP takes over the register directly
			if (res_valid_q && pop && state_q != S_RESP) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						cur_q      <= op;
						pend_pix_q <= '0;
						pend_st_q  <= op.oob && (op.op == OP_WRITE || op.op == OP_READ);
						i_q        <= op.lo;
						if (op.op == OP_DRAW) state_q <= S_BASE;
						else if (op.op == OP_READ && !op.oob) state_q <= S_RD;
						else state_q <= S_RESP;
					end
				end
				S_RD: begin
					pend_pix_q <= rd_data_q;
					state_q    <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						res_valid_q     <= 1'b1;
						res_q.pixel_out <= pend_pix_q;
						res_q.status    <= pend_st_q;
						state_q         <= S_IDLE;
					end
				end
				S_BASE: begin
					bprod_q <= cur_q.b1 * cur_q.dmaj;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= (13'(i_q) - 13'(cur_q.a1)) * cur_q.dmin;
					state_q <= S_DIVI;
				end
				S_DIVI: begin
					rem_q <= '0;
					cnt_q <= '0;
					if (cur_q.dmaj == 0) begin
						// equal endpoints: one brush at the start point
						n_q     <= cur_q.b1 < 0 ? 27'(-cur_q.b1) : 27'(cur_q.b1);
						neg_q   <= cur_q.b1 < 0;
						state_q <= S_BSET;
					end else begin
						n_q     <= nabs;
						neg_q   <= (num < 0) != (cur_q.dmaj < 0);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= qbit ? 13'(trial - {1'b0, dabs}) : trial[12:0];
					n_q   <= {n_q[25:0], qbit};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd26) state_q <= S_BSET;
				end
				S_BSET: begin
					r_q    <= r0;
					c_q    <= c0;
					c0_q   <= c0;
					rend_q <= rend;
					cend_q <= cend;
					state_q <= (r0 < rend && c0 < cend) ? S_PAINT : S_NEXT;
				end
				S_PAINT: begin
					if (c_q + 14'sd1 == cend_q) begin
						c_q <= c0_q;
						if (r_q + 14'sd1 == rend_q) state_q <= S_NEXT;
						else r_q <= r_q + 14'sd1;
					end else begin
						c_q <= c_q + 14'sd1;
					end
				end
				S_NEXT: begin
					if (i_q == cur_q.hi) begin
						state_q <= S_RESP;
					end else begin
						i_q     <= i_q + 12'sd1;
						state_q <= S_MUL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/thick_line_raster_top.sv
// Access: S_RESP, reads S_RD first. Draw, per major step: S_MUL, S_DIVI,
// serial divide, S_BSET, S_PAINT over the brush area, S_NEXT. One item at a
// time in the back end, set by the serial divider and the single frame-store
// write port (one pixel/cycle). Front queue holds two items, result register
// one; both sides stall apart. Reset (arst_n, async low) sets control and
// config to reset values; frame store is not cleared, unknown until written.
module thick_line_raster_top #(
	parameter int MAX_ROWS       = tlr_pkg::TLR_MAX_ROWS,
	parameter int MAX_COLS       = tlr_pkg::TLR_MAX_COLS,
	parameter int MAX_LINE_WIDTH = tlr_pkg::TLR_MAX_LINE_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  tlr_pkg::tlr_item_t   item,
	output logic                 empty,
	input  logic                 pop,
	output tlr_pkg::tlr_result_t result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_wdata
);
	import tlr_pkg::*;

	// configuration registers
	logic [23:0] color_q;
	logic [4:0]  lwidth_q;
	logic [8:0]  height_q, width_q;

	// clamped bounds and brush half-width
	logic [DIM_W-1:0]  rows_lim, cols_lim;
	logic [HALF_W-1:0] half;
	logic [7:0]        lw_eff;

	tlr_op_t op;
	logic    op_valid, op_ready, res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= '0;
			lwidth_q <= 5'd1;
			height_q <= 9'd256;
			width_q  <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR:  color_q  <= cfg_wdata;
				REG_LWIDTH: lwidth_q <= cfg_wdata[4:0];
				REG_HEIGHT: height_q <= cfg_wdata[8:0];
				REG_WIDTH:  width_q  <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// bounds above the store are used as the store size, widths above MAX_LINE_WIDTH as it
	always_comb begin
		rows_lim = (32'(height_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : DIM_W'(height_q);
		cols_lim = (32'(width_q) > MAX_COLS) ? DIM_W'(MAX_COLS) : DIM_W'(width_q);
		lw_eff   = (32'(lwidth_q) > MAX_LINE_WIDTH) ? 8'(MAX_LINE_WIDTH) : 8'(lwidth_q);
		half     = HALF_W'(lw_eff >> 1);
	end

	tlr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.rows_lim (rows_lim),
		.cols_lim (cols_lim),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	tlr_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.color     (color_q),
		.half      (half),
		.rows_lim  (rows_lim),
		.cols_lim  (cols_lim),
		.pop       (pop),
		.res_valid (res_valid),
		.result    (result)
	);

	// result side shows the oldest waiting transfer while not empty
	assign empty = !res_valid;

endmodule

### rtl/tlr_checker.sv
// Port-level checks of the thick line rasteriser, bound to the top level.
// Depends on tlr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input logic                 empty,
	input logic                 pop,
	input tlr_pkg::tlr_result_t result
);

	`TLR_ASSERT_NEXT(a_res_held, clk, arst_n, !empty && !pop, !empty, "result dropped")
	`TLR_ASSERT_NEXT(a_res_stable, clk, arst_n, !empty && !pop, $stable(result), "result changed")
	`TLR_ASSERT_NOW(a_oob_zero, clk, arst_n, !empty && result.status, result.pixel_out == 24'd0, "out of range access returned data")
	`TLR_ASSERT_NEXT(a_full_no_push, clk, arst_n, !full && !push, !full, "queue filled without transfer")

endmodule

bind thick_line_raster_top tlr_checker u_tlr_checker (.*);
